// ----- hdl/byte_ring_buffer_multiwidth_defines.svh -----
// assertion macros for the byte ring buffer
// used by byte_ring_buffer_multiwidth.sv, expects clk and arst_n in scope
`ifndef BYTE_RING_BUFFER_MULTIWIDTH_DEFINES_SVH
`define BYTE_RING_BUFFER_MULTIWIDTH_DEFINES_SVH

// checked outside reset only
`define BRBM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BRBM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/brbm_pkg.sv -----
// shared types and constants for the byte ring buffer
// no dependencies; imported by every module of the block
`default_nettype none

package brbm_pkg;

	localparam int CAPACITY  = 4096;
	localparam int PTR_W     = $clog2(CAPACITY);
	localparam int CNT_W     = 13;
	localparam int LANES     = 8;
	localparam int LANE_W    = $clog2(LANES);
	localparam int ROWS      = CAPACITY / LANES;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int DATA_W    = 64;
	localparam int SIZE_W    = 4;
	localparam int IN_W      = 72;
	localparam int IN_USER_W = 3;
	localparam int OUT_W     = 96;

	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_POP   = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_NO_DATA = 2'd1,
		ST_NO_ROOM = 2'd2
	} status_t;

	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [PTR_W-1:0]  base;
		logic [SIZE_W-1:0] n;
		logic              be;
		logic [DATA_W-1:0] data;
	} lane_req_t;

	typedef struct packed {
		logic              pop_ok;
		logic [LANE_W-1:0] off;
		logic [SIZE_W-1:0] n;
		logic              be;
	} merge_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/byte_ring_buffer_multiwidth.sv -----
// Circular byte FIFO, 4096 bytes, push or pop of up to 8 bytes per word.
// Slave channel s_*: one operation per word, kind and byte order in s_tuser.
// Master channel m_*: one result word per operation, in order.
// The store is split over eight byte banks, one per byte lane, so a word of up
// to eight bytes touches each bank at most once and all banks work together.
// Pointers and count update at the edge a word is accepted; the bank read is
// registered and the merge stage assembles the popped value in the cycle after.
// Each result passes the bank read and merge-stage registers, then the output
// register that drives m_tvalid and m_tdata.
// Throughput: one word per cycle while the receiver keeps m_tready high.
// When the receiver stalls, the result is held in the output register, one more
// word can sit in the merge stage, and s_tready drops until space frees up.
// A failed push or pop reports its status and leaves the buffer unchanged.
// Reset empties the buffer (pointers and count to zero) and drops both valids;
// no clearing pass runs, bank contents are simply never read before written.
// Depends on brbm_pkg, brbm_lane, brbm_merge and the defines header.
`default_nettype none

`include "byte_ring_buffer_multiwidth_defines.svh"

module byte_ring_buffer_multiwidth
	import brbm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_W-1:0]      s_tdata,  // size_bytes[3:0], write_data[67:4], zero pad
	input  wire logic [IN_USER_W-1:0] s_tuser,  // kind[1:0], big_endian[2]
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [OUT_W-1:0]          m_tdata   // read_data[63:0], status[65:64],
	                                            // fill_level[78:66], free_space[91:79], zero pad
);

	logic [PTR_W-1:0]  rp_q, wp_q, rp_nx, wp_nx;
	logic [CNT_W-1:0]  count_q, count_nx, room;
	logic [SIZE_W-1:0] size, n;
	kind_t             kind;
	status_t           status_nx;
	logic              be;
	logic              push_go, pop_go, acc, adv;
	lane_req_t         req;

	logic              v_s1;
	status_t           status_s1;
	logic [CNT_W-1:0]  fill_s1;
	merge_ctl_t        ctl_s1;

	logic [7:0]        lane_byte [LANES];
	logic [DATA_W-1:0] merged;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	always_comb begin
		kind      = kind_t'(s_tuser[1:0]);
		be        = s_tuser[2];
		size      = s_tdata[SIZE_W-1:0];
		n         = (size > SIZE_W'(8)) ? SIZE_W'(8) : size;
		room      = CNT_W'(CAPACITY) - count_q;
		status_nx = ST_DONE;
		count_nx  = count_q;
		wp_nx     = wp_q;
		rp_nx     = rp_q;
		push_go   = 1'b0;
		pop_go    = 1'b0;
		case (kind)
			KIND_PUSH: begin
				if (CNT_W'(n) > room) begin
					status_nx = ST_NO_ROOM;
				end else begin
					push_go  = 1'b1;
					count_nx = count_q + CNT_W'(n);
					wp_nx    = wp_q + PTR_W'(n);
				end
			end
			KIND_POP: begin
				if (CNT_W'(n) > count_q) begin
					status_nx = ST_NO_DATA;
				end else begin
					pop_go   = 1'b1;
					count_nx = count_q - CNT_W'(n);
					rp_nx    = rp_q + PTR_W'(n);
				end
			end
			KIND_CLEAR: begin
				count_nx = '0;
				wp_nx    = '0;
				rp_nx    = '0;
			end
			default: ;
		endcase
	end

	assign adv      = v_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !v_s1 || adv;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		req.wr_en = acc && push_go;
		req.rd_en = acc && pop_go;
		req.base  = push_go ? wp_q : rp_q;
		req.n     = n;
		req.be    = be;
		req.data  = s_tdata[SIZE_W +: DATA_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q    <= '0;
			wp_q    <= '0;
			count_q <= '0;
		end else if (acc) begin
			rp_q    <= rp_nx;
			wp_q    <= wp_nx;
			count_q <= count_nx;
		end
	end

	// lane banks
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		brbm_lane #(
			.LANE(g)
		) u_lane (
			.clk    (clk),
			.req    (req),
			.rd_byte(lane_byte[g])
		);
	end

	// merge stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1  <= status_nx;
			fill_s1    <= count_nx;
			ctl_s1.pop_ok <= pop_go;
			ctl_s1.off    <= rp_q[LANE_W-1:0];
			ctl_s1.n      <= n;
			ctl_s1.be     <= be;
		end
	end

	brbm_merge u_merge (
		.lane_byte(lane_byte),
		.ctl      (ctl_s1),
		.value    (merged)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_q <= {4'b0000, CNT_W'(CAPACITY) - fill_s1, fill_s1, status_s1, merged};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`BRBM_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !m_tvalid_q && !v_s1, "valid left after reset")
	`BRBM_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "byte count above capacity")
	`BRBM_ASSERT(a_ptr_match, (wp_q - rp_q) == count_q[PTR_W-1:0], "pointers disagree with count")
	`BRBM_ASSERT(a_fail_keeps,
		acc && (status_nx != ST_DONE) |=> (count_q == $past(count_q)) &&
		(wp_q == $past(wp_q)) && (rp_q == $past(rp_q)),
		"failed operation changed state")
	`BRBM_ASSERT(a_fail_zero,
		m_tvalid_q && (m_tdata_q[65:64] != ST_DONE) |-> (m_tdata_q[63:0] == '0),
		"failed operation returned data")

endmodule

`default_nettype wire

// ----- hdl/brbm_lane.sv -----
// one byte bank of the ring store: picks its byte of a word, writes or reads one row
// depends on brbm_pkg
`default_nettype none

module brbm_lane
	import brbm_pkg::*;
#(
	parameter int LANE = 0
) (
	input  wire logic      clk,
	input  wire lane_req_t req,
	output logic [7:0]     rd_byte
);

	localparam logic [LANE_W-1:0] LANE_IDX = LANE_W'(LANE);

	logic [7:0]        mem [ROWS];
	logic [LANE_W-1:0] k;
	logic [LANE_W-1:0] sel;
	logic [PTR_W-1:0]  addr;
	logic [ROW_W-1:0]  row;
	logic              active;
	logic [7:0]        wr_byte;
	logic [DATA_W-1:0] shifted;

	always_comb begin
		k       = LANE_IDX - req.base[LANE_W-1:0];
		active  = {1'b0, k} < req.n;
		addr    = req.base + PTR_W'(k);
		row     = addr[PTR_W-1:LANE_W];
		sel     = req.be ? (req.n[LANE_W-1:0] - LANE_W'(1) - k) : k;
		shifted = req.data >> {sel, 3'b000};
		wr_byte = shifted[7:0];
	end

	always_ff @(posedge clk) begin
		if (req.wr_en && active) begin
			mem[row] <= wr_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en && active) begin
			rd_byte <= mem[row];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/brbm_merge.sv -----
// gathers the bank read bytes into the popped value, in either byte order
// depends on brbm_pkg
`default_nettype none

module brbm_merge
	import brbm_pkg::*;
(
	input  wire logic [7:0]   lane_byte [LANES],
	input  wire merge_ctl_t   ctl,
	output logic [DATA_W-1:0] value
);

	always_comb begin
		logic [LANE_W-1:0] i;
		logic [LANE_W-1:0] bank;
		value = '0;
		for (int j = 0; j < LANES; j++) begin
			i    = ctl.be ? (ctl.n[LANE_W-1:0] - LANE_W'(1) - LANE_W'(j)) : LANE_W'(j);
			bank = ctl.off + i;
			if (ctl.pop_ok && (SIZE_W'(j) < ctl.n)) begin
				value[j*8 +: 8] = lane_byte[bank];
			end
		end
	end

endmodule

`default_nettype wire
